FILE: sv/heading_pd_drive_steering_top_assert.svh
// Assertion macros for the heading PD drive steering block
`ifndef HEADING_PD_DRIVE_STEERING_TOP_ASSERT_SVH
`define HEADING_PD_DRIVE_STEERING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HPDS_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HPDS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HPDS_CHECK(label, ante, cons, msg)
`define HPDS_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/hpds_pkg.sv
// Shared types and constants for the heading PD drive steering block
`default_nettype none
package hpds_pkg;
	typedef logic signed [14:0] angle_t;
	typedef logic signed [15:0] err_t;
	typedef logic signed [16:0] diff_t;
	typedef logic [14:0] mag_t;
	typedef logic signed [10:0] turn_t;
	typedef logic [9:0] speed_lim_t;
	typedef logic signed [11:0] duty_t;

	localparam int TURN_MAX = 1023;
	localparam int NUM_W = 26;
	localparam int RECIP_W = NUM_W + 1;
	localparam int QUOT_W = 11;

	typedef enum logic [1:0] {
		REG_GAIN_P      = 2'd0,
		REG_GAIN_D      = 2'd1,
		REG_SPEED_LIMIT = 2'd2
	} reg_idx_t;
endpackage
`default_nettype wire

FILE: sv/hpds_err.sv
// Heading error with single wrap, previous error substitution and magnitude
`default_nettype none
module hpds_err import hpds_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = 12
) (
	input  angle_t heading,
	input  angle_t bearing,
	input  err_t   prev_err,
	output err_t   err,
	output diff_t  diff,
	output mag_t   err_mag
);
	localparam int PI_FX = (3145 * (1 << ANGLE_FRACTION_BITS) + 500) / 1000;
	localparam logic signed [18:0] PI_W = 19'(PI_FX);
	localparam logic signed [18:0] TWO_PI_W = 19'(2 * PI_FX);

	logic signed [18:0] raw;
	logic signed [18:0] wrapped;
	err_t prev_eff;
	err_t err_abs;

	always_comb begin
		raw = 19'(heading) - 19'(bearing);
		if (raw > PI_W) begin
			wrapped = raw - TWO_PI_W;
		end else if (raw < -PI_W) begin
			wrapped = raw + TWO_PI_W;
		end else begin
			wrapped = raw;
		end
		err = wrapped[15:0];
		prev_eff = (prev_err == '0) ? err : prev_err;
		diff = 17'(err) - 17'(prev_eff);
		err_abs = err[15] ? -err : err;
		err_mag = err_abs[14:0];
	end
endmodule
`default_nettype wire

FILE: sv/hpds_turn.sv
// PD sum, truncation toward zero and turn saturation
`default_nettype none
module hpds_turn import hpds_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = 12
) (
	input  logic signed [31:0] prod_p,
	input  logic signed [32:0] prod_d,
	output turn_t              turn
);
	localparam int SH = 8 + ANGLE_FRACTION_BITS;

	logic signed [33:0] sum;
	logic [33:0] sum_mag;
	logic [33:0] shifted;
	logic [9:0] turn_mag;
	turn_t turn_pos;

	always_comb begin
		sum = 34'(prod_p) + 34'(prod_d);
		sum_mag = sum[33] ? 34'(-sum) : 34'(sum);
		shifted = sum_mag >> SH;
		turn_mag = (shifted > 34'(TURN_MAX)) ? 10'(TURN_MAX) : shifted[9:0];
		turn_pos = turn_t'({1'b0, turn_mag});
		turn = sum[33] ? -turn_pos : turn_pos;
	end
endmodule
`default_nettype wire

FILE: sv/hpds_speed.sv
// Speed taper, turn cap and saturated wheel duties
`default_nettype none
module hpds_speed import hpds_pkg::*; (
	input  turn_t             turn,
	input  logic [QUOT_W-1:0] quot,
	input  logic              over,
	input  speed_lim_t        limit,
	output duty_t             left_duty,
	output duty_t             right_duty
);
	logic signed [12:0] lim_x;
	logic signed [12:0] spd;
	logic signed [12:0] cap;
	logic signed [12:0] spd_sel;
	logic signed [12:0] left_x;
	logic signed [12:0] right_x;
	turn_t turn_abs;

	function automatic duty_t sat12(input logic signed [12:0] v);
		duty_t r;
		if (v > 13'sd2047) begin
			r = 12'sd2047;
		end else if (v < -13'sd2048) begin
			r = -12'sd2048;
		end else begin
			r = v[11:0];
		end
		return r;
	endfunction

	always_comb begin
		lim_x = 13'({3'b000, limit});
		turn_abs = turn[10] ? -turn : turn;
		spd = over ? '0 : lim_x - 13'({2'b00, quot});
		cap = lim_x - 13'(turn_abs);
		spd_sel = (spd > cap) ? cap : spd;
		left_x = spd_sel - 13'(turn);
		right_x = spd_sel + 13'(turn);
		left_duty = sat12(left_x);
		right_duty = sat12(right_x);
	end
endmodule
`default_nettype wire

FILE: sv/heading_pd_drive_steering_top.sv
// Top level of the heading PD drive steering block.
// Takes one heading/bearing transaction per cycle while the output side is not
// stalled, and returns one left/right duty transaction for each, in the order taken.
// The five pipeline stages are input register, heading error, the gain and
// taper multiplies, the turn sum with the reciprocal taper divide, and the output
// register; each stage advances when the next one is empty or moving, so bubbles
// collapse and input is taken while a result waits. The previous error is updated
// as an item leaves the input register, so consecutive items see each other's error.
// Configuration writes take effect at once and must only occur while the block is idle.
`default_nettype none
`include "heading_pd_drive_steering_top_assert.svh"
module heading_pd_drive_steering_top import hpds_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // robot_heading [14:0], goal_bearing [29:15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // left_duty [11:0], right_duty [23:12]
);
	localparam int CUT_FX = (6290 * (1 << ANGLE_FRACTION_BITS) + 1500) / 3000;
	localparam int SHIFT_K = NUM_W + $clog2(CUT_FX);
	localparam int PROD_W = NUM_W + RECIP_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT_K) + longint'(CUT_FX) - 64'd1) / longint'(CUT_FX);
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP_L);

	logic signed [15:0] gain_p_q;
	logic signed [15:0] gain_d_q;
	speed_lim_t speed_limit_q;
	err_t prev_err_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	angle_t heading_s1, bearing_s1;
	err_t err_s2;
	diff_t diff_s2;
	mag_t mag_s2;
	logic signed [31:0] pp_s3;
	logic signed [32:0] pd_s3;
	logic [NUM_W-1:0] num_s3;
	logic over_s3;
	turn_t turn_s4;
	logic [QUOT_W-1:0] quot_s4;
	logic over_s4;
	duty_t left_s5, right_s5;

	err_t err_c;
	diff_t diff_c;
	mag_t mag_c;
	logic signed [31:0] pp_c;
	logic signed [32:0] pd_c;
	logic [NUM_W-1:0] num_c;
	logic over_c;
	turn_t turn_c;
	logic [PROD_W-1:0] qprod_c;
	duty_t left_c, right_c;

	assign en_s5 = !v_s5 || m_tready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = v_s5;
	assign m_tdata = {right_s5, left_s5};

	hpds_err #(
		.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
	) u_err (
		.heading (heading_s1),
		.bearing (bearing_s1),
		.prev_err(prev_err_q),
		.err     (err_c),
		.diff    (diff_c),
		.err_mag (mag_c)
	);

	assign pp_c = gain_p_q * err_s2;
	assign pd_c = gain_d_q * diff_s2;
	assign num_c = NUM_W'(speed_limit_q) * NUM_W'(mag_s2) + NUM_W'(CUT_FX - 1);
	assign over_c = int'(mag_s2) > CUT_FX;

	hpds_turn #(
		.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
	) u_turn (
		.prod_p(pp_s3),
		.prod_d(pd_s3),
		.turn  (turn_c)
	);

	assign qprod_c = PROD_W'(num_s3) * PROD_W'(RECIP_V);

	hpds_speed u_speed (
		.turn      (turn_s4),
		.quot      (quot_s4),
		.over      (over_s4),
		.limit     (speed_limit_q),
		.left_duty (left_c),
		.right_duty(right_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= 16'sd256;
			gain_d_q <= '0;
			speed_limit_q <= 10'd200;
			prev_err_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_GAIN_P: gain_p_q <= cfg_wdata;
					REG_GAIN_D: gain_d_q <= cfg_wdata;
					REG_SPEED_LIMIT: speed_limit_q <= cfg_wdata[9:0];
					default: ;
				endcase
			end
			if (v_s1 && en_s2) begin
				prev_err_q <= err_c;
			end
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			heading_s1 <= s_tdata[14:0];
			bearing_s1 <= s_tdata[29:15];
		end
		if (en_s2) begin
			err_s2 <= err_c;
			diff_s2 <= diff_c;
			mag_s2 <= mag_c;
		end
		if (en_s3) begin
			pp_s3 <= pp_c;
			pd_s3 <= pd_c;
			num_s3 <= num_c;
			over_s3 <= over_c;
		end
		if (en_s4) begin
			turn_s4 <= turn_c;
			quot_s4 <= qprod_c[SHIFT_K +: QUOT_W];
			over_s4 <= over_s3;
		end
		if (en_s5) begin
			left_s5 <= left_c;
			right_s5 <= right_c;
		end
	end

	`HPDS_CHECK(a_turn_range, v_s4, (turn_s4 <= 11'sd1023) && (turn_s4 >= -11'sd1023), "turn out of range")
	`HPDS_CHECK(a_quot_limit, v_s4 && !over_s4, quot_s4 <= {1'b0, speed_limit_q}, "taper step above limit")
	`HPDS_CHECK_NEXT(a_prev_update, v_s1 && en_s2, prev_err_q == $past(err_c), "previous error not held")
	`HPDS_CHECK(a_accept_free, !m_tvalid, s_tready, "input stalled with empty output")
endmodule
`default_nettype wire

FILE: dv/heading_pd_drive_steering_top_tb.sv
// Self-checking testbench for the heading PD drive steering block, with scoreboard and stream drivers
module heading_pd_drive_steering_top_tb import hpds_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_FRACTION_BITS = 12;
	localparam longint PI_FX = (3145 * (longint'(1) << ANGLE_FRACTION_BITS) + 500) / 1000;
	localparam longint TWO_PI_FX = 2 * PI_FX;
	localparam longint CUT_FX = (6290 * (longint'(1) << ANGLE_FRACTION_BITS) + 1500) / 3000;
	localparam longint TURN_LIMIT = 1023;
	localparam longint DUTY_HI = 2047;
	localparam longint DUTY_LO = -2048;
	localparam logic [1:0] REG_BAD = 2'd3;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_STRETCH = 300;

	typedef struct {
		duty_t left;
		duty_t right;
	} duty_pair_t;

	class duty_scoreboard;
		longint gain_p;
		longint gain_d;
		longint speed_limit;
		longint prev_error;
		duty_pair_t expected_duties[$];
		int mismatches;

		function new();
			gain_p = 256;
			gain_d = 0;
			speed_limit = 200;
			prev_error = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_GAIN_P: gain_p = longint'($signed(val));
				REG_GAIN_D: gain_d = longint'($signed(val));
				REG_SPEED_LIMIT: speed_limit = longint'(val[9:0]);
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void note_pose(angle_t heading, angle_t bearing);
			longint err, sum, turn, speed, cap, aerr, aturn;
			duty_pair_t pair;
			err = longint'(heading) - longint'(bearing);
			if (err > PI_FX)
				err = err - TWO_PI_FX;
			else if (err < -PI_FX)
				err = err + TWO_PI_FX;
			if (prev_error == 0)
				prev_error = err;
			sum = gain_p * err + gain_d * (err - prev_error);
			turn = sum / (longint'(1) << (8 + ANGLE_FRACTION_BITS));
			turn = clip(turn, -TURN_LIMIT, TURN_LIMIT);
			prev_error = longint'(err_t'(err));
			aerr = (err < 0) ? -err : err;
			if (aerr <= CUT_FX)
				speed = speed_limit - (speed_limit * aerr + CUT_FX - 1) / CUT_FX;
			else
				speed = 0;
			aturn = (turn < 0) ? -turn : turn;
			cap = speed_limit - aturn;
			if (speed > cap)
				speed = cap;
			pair.left = duty_t'(clip(speed - turn, DUTY_LO, DUTY_HI));
			pair.right = duty_t'(clip(speed + turn, DUTY_LO, DUTY_HI));
			expected_duties.push_back(pair);
		endfunction

		function void check_duties(logic [23:0] data);
			duty_pair_t want;
			duty_t got_left, got_right;
			got_left = duty_t'(data[11:0]);
			got_right = duty_t'(data[23:12]);
			if (expected_duties.size() == 0) begin
				$display("%0t unexpected result: left %0d right %0d", $time, got_left, got_right);
				mismatches++;
				return;
			end
			want = expected_duties.pop_front();
			if (got_left !== want.left) begin
				$display("%0t left_duty mismatch: expected %0d actual %0d",
					$time, want.left, got_left);
				mismatches++;
			end
			if (got_right !== want.right) begin
				$display("%0t right_duty mismatch: expected %0d actual %0d",
					$time, want.right, got_right);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;

	duty_scoreboard sb;
	bit quiet;
	int hold_cycles;
	int stall_count;

	heading_pd_drive_steering_top #(
		.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_pose(angle_t'(s_tdata[14:0]), angle_t'(s_tdata[29:15]));
			if (m_tvalid && m_tready)
				sb.check_duties(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	function automatic int rand_gap();
		if (quiet)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	task automatic send_pose(input angle_t heading, input angle_t bearing);
		int gap;
		s_tdata <= {2'b00, bearing, heading};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = rand_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(input logic [15:0] gp, input logic [15:0] gd, input logic [9:0] lim);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_SPEED_LIMIT, {6'($urandom), lim});
		write_reg(REG_BAD, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_duties.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 4096)) - 2048);
			2: return 16'(int'($urandom_range(0, 1024)) - 512);
			default: return 16'(int'($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	task automatic send_random_pose();
		int h, b;
		longint edges[8];
		edges = '{PI_FX, PI_FX + 1, -PI_FX, -PI_FX - 1, CUT_FX, CUT_FX + 1, -CUT_FX, -CUT_FX - 1};
		h = int'($urandom_range(0, 25764)) - 12882;
		b = int'($urandom_range(0, 25764)) - 12882;
		case ($urandom_range(0, 9))
			5, 6: begin
				h = int'(angle_t'($urandom));
				b = int'(angle_t'($urandom));
			end
			7: b = h + int'($urandom_range(0, 600)) - 300;
			8: b = h;
			9: b = h - int'(edges[$urandom_range(0, 7)]);
			default: ;
		endcase
		send_pose(angle_t'(h), angle_t'(b));
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		hold_cycles = 0;
		stall_count = 0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAIN_P;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_pose(0, 0);
		send_pose(1000, 0);
		send_pose(12882, 0);
		send_pose(12883, 0);
		send_pose(-12882, 0);
		send_pose(-12883, 0);
		send_pose(16383, -16384);
		send_pose(-16384, 16383);
		send_pose(8588, 0);
		send_pose(8589, 0);
		send_pose(-8588, 0);
		send_pose(0, 0);
		send_pose(500, 0);
		wait_drained();

		set_config(16'sd32767, -16'sd32768, 10'd1023);
		send_pose(12882, 0);
		send_pose(-12882, 0);
		send_pose(100, 0);
		send_pose(-100, 0);
		send_pose(0, 0);
		send_pose(3000, -3000);
		send_pose(-16384, -16384);
		send_pose(16383, 16383);
		wait_drained();

		set_config(rand_gain(), rand_gain(), 10'($urandom));
		quiet = 1'b1;
		hold_cycles = HOLD_STRETCH;
		repeat (40) send_random_pose();
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0)
				set_config(-16'sd32768, 16'sd32767, 10'd0);
			else if (phase == 1)
				set_config(16'sd0, 16'sd0, 10'd1023);
			else
				set_config(rand_gain(), rand_gain(), 10'($urandom));
			quiet = ($urandom_range(0, 3) == 0);
			repeat (65) send_random_pose();
			wait_drained();
		end

		if (sb.expected_duties.size() != 0) begin
			$display("%0t %0d results never arrived", $time, sb.expected_duties.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = rand_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end
endmodule
